>>> hdl/temperature_alarm_monitor_unit_defines.svh
// Assertion helpers for the temperature alarm monitor
`ifndef TEMPERATURE_ALARM_MONITOR_UNIT_DEFINES_SVH
`define TEMPERATURE_ALARM_MONITOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TAMU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tamu: same-cycle check failed");
// next-cycle implication
`define TAMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tamu: next-cycle check failed");
`else
`define TAMU_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TAMU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/tamu_pkg.sv
`timescale 1ns / 1ps

package tamu_pkg;

    localparam int TEMP_W       = 16;
    localparam int BATT_W       = 12;
    localparam int PERIOD_W     = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int MODE_W       = 2;

    localparam int TIMER_BITS_DEFAULT = 16;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam mode_t MODE_NORMAL   = 2'd0;
    localparam mode_t MODE_WARNING  = 2'd1;
    localparam mode_t MODE_CRITICAL = 2'd2;
    localparam mode_t MODE_MUTED    = 2'd3;

    localparam cfg_idx_t CFG_WARN_HIGH      = 3'd0;
    localparam cfg_idx_t CFG_WARN_LOW       = 3'd1;
    localparam cfg_idx_t CFG_CRIT_HIGH      = 3'd2;
    localparam cfg_idx_t CFG_CRIT_LOW       = 3'd3;
    localparam cfg_idx_t CFG_BATTERY_LOW    = 3'd4;
    localparam cfg_idx_t CFG_MEASURE_PERIOD = 3'd5;
    localparam cfg_idx_t CFG_MUTE_LENGTH    = 3'd6;

    localparam logic signed [TEMP_W-1:0] WARN_HIGH_RST = 16'sd4928;
    localparam logic signed [TEMP_W-1:0] WARN_LOW_RST  = 16'sd4352;
    localparam logic signed [TEMP_W-1:0] CRIT_HIGH_RST = 16'sd5376;
    localparam logic signed [TEMP_W-1:0] CRIT_LOW_RST  = 16'sd3840;
    localparam logic [BATT_W-1:0]        BATT_LOW_RST  = 12'd3003;
    localparam logic [PERIOD_W-1:0]      MEASURE_RST   = 16'd2000;
    localparam logic [PERIOD_W-1:0]      MUTE_RST      = 16'd30000;

    // blink half-periods in ticks
    localparam logic [PERIOD_W-1:0] BLINK_SLOW   = 16'd2000;
    localparam logic [PERIOD_W-1:0] BLINK_MEDIUM = 16'd500;
    localparam logic [PERIOD_W-1:0] BLINK_FAST   = 16'd200;

endpackage

>>> hdl/tamu_sample_if.sv
`timescale 1ns / 1ps

interface tamu_sample_if import tamu_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     button_press;
    logic signed [TEMP_W-1:0] temp_sample;
    logic                     sensor_fault;
    logic [BATT_W-1:0]        battery_sample;

    modport source (output valid, button_press, temp_sample, sensor_fault, battery_sample,
                    input ready);
    modport sink (input valid, button_press, temp_sample, sensor_fault, battery_sample,
                  output ready);
endinterface

>>> hdl/tamu_result_if.sv
`timescale 1ns / 1ps

interface tamu_result_if import tamu_pkg::*;;
    logic  valid;
    logic  ready;
    logic  led_drive;
    logic  buzzer_drive;
    mode_t alarm_mode;
    logic  evaluated;

    modport source (output valid, led_drive, buzzer_drive, alarm_mode, evaluated,
                    input ready);
    modport sink (input valid, led_drive, buzzer_drive, alarm_mode, evaluated,
                  output ready);
endinterface

>>> hdl/tamu_cfg_if.sv
`timescale 1ns / 1ps

interface tamu_cfg_if import tamu_pkg::*;;
    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/temperature_alarm_monitor_unit.sv
// A result appears on the output register in the cycle after its sample transfer.
// Throughput: one sample per cycle; the output register stalls intake only when full
// and not being taken. The state update is one pass of compare/counter logic.
// Reset (rst_n, async, active low): mode normal, counters, blink phase, LED and buzzer
// cleared, thresholds and periods back to their defaults, output register empty.
`timescale 1ns / 1ps
`include "temperature_alarm_monitor_unit_defines.svh"

module temperature_alarm_monitor_unit import tamu_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    tamu_sample_if.sink   samples,
    tamu_result_if.source results,
    tamu_cfg_if.sink      cfg
);

    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    // configuration
    logic signed [TEMP_W-1:0] warn_high_reg, warn_low_reg, crit_high_reg, crit_low_reg;
    logic [BATT_W-1:0]        battery_low_reg;
    logic [PERIOD_W-1:0]      measure_period_reg, mute_length_reg;

    // tick state
    mode_t                 mode_reg, mode_next;
    logic [TIMER_BITS-1:0] since_measure_reg, since_measure_next;
    logic [TIMER_BITS-1:0] since_blink_reg, since_blink_next;
    logic [TIMER_BITS-1:0] since_mute_reg, since_mute_next;
    logic                  blink_phase_reg, blink_phase_next;
    logic                  led_reg, led_next;
    logic                  buzzer_reg, buzzer_next;
    logic                  evaluated_next;

    // output register
    logic  out_valid_reg;
    logic  out_led_reg, out_buzzer_reg, out_eval_reg;
    mode_t out_mode_reg;

    logic in_xfer;
    logic out_xfer;
    logic cfg_xfer;

    logic [TIMER_BITS-1:0] sm_inc, sb_inc, su_inc;
    logic [PERIOD_W-1:0]   blink_period;
    logic signed [TEMP_W-1:0] temp_eff;
    logic                  is_crit, is_warn;

    assign samples.ready = !out_valid_reg || results.ready;
    assign in_xfer       = samples.valid && samples.ready;
    assign out_xfer      = results.valid && results.ready;
    assign cfg.ready     = 1'b1;
    assign cfg_xfer      = cfg.valid && cfg.ready;

    assign results.valid        = out_valid_reg;
    assign results.led_drive    = out_led_reg;
    assign results.buzzer_drive = out_buzzer_reg;
    assign results.alarm_mode   = out_mode_reg;
    assign results.evaluated    = out_eval_reg;

    assign sm_inc = (since_measure_reg == TMAX) ? TMAX : since_measure_reg + 1'b1;
    assign sb_inc = (since_blink_reg == TMAX) ? TMAX : since_blink_reg + 1'b1;
    assign su_inc = (since_mute_reg == TMAX) ? TMAX : since_mute_reg + 1'b1;

    assign temp_eff = samples.sensor_fault ? '0 : samples.temp_sample;
    assign is_crit  = (temp_eff < crit_low_reg) || (temp_eff > crit_high_reg)
                      || (samples.battery_sample < battery_low_reg);
    assign is_warn  = (temp_eff < warn_low_reg) || (temp_eff > warn_high_reg);

    always_comb
    begin
        mode_t m;
        m                  = mode_reg;
        since_measure_next = sm_inc;
        since_blink_next   = sb_inc;
        since_mute_next    = su_inc;
        blink_phase_next   = blink_phase_reg;
        led_next           = led_reg;
        buzzer_next        = buzzer_reg;
        evaluated_next     = 1'b0;

        if (samples.button_press && (m == MODE_WARNING || m == MODE_CRITICAL))
        begin
            m               = MODE_MUTED;
            since_mute_next = '0;
            buzzer_next     = 1'b0;
        end

        if (m == MODE_MUTED && since_mute_next > TIMER_BITS'(mute_length_reg))
        begin
            m = MODE_NORMAL;
        end

        if (since_measure_next >= TIMER_BITS'(measure_period_reg))
        begin
            since_measure_next = '0;
            evaluated_next     = 1'b1;
            if (m != MODE_MUTED)
            begin
                if (is_crit)
                    m = MODE_CRITICAL;
                else if (is_warn)
                    m = MODE_WARNING;
                else
                    m = MODE_NORMAL;
            end
        end

        case (m)
            MODE_NORMAL:   blink_period = BLINK_SLOW;
            MODE_WARNING:  blink_period = BLINK_MEDIUM;
            default:       blink_period = BLINK_FAST;
        endcase

        if (m == MODE_MUTED)
        begin
            led_next    = 1'b1;
            buzzer_next = 1'b0;
        end
        else
        begin
            if (since_blink_next >= TIMER_BITS'(blink_period))
            begin
                since_blink_next = '0;
                blink_phase_next = !blink_phase_reg;
                led_next         = !blink_phase_reg;
                if (m == MODE_CRITICAL)
                    buzzer_next = !blink_phase_reg;
            end
            if (m != MODE_CRITICAL)
                buzzer_next = 1'b0;
        end

        mode_next = m;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_high_reg      <= WARN_HIGH_RST;
            warn_low_reg       <= WARN_LOW_RST;
            crit_high_reg      <= CRIT_HIGH_RST;
            crit_low_reg       <= CRIT_LOW_RST;
            battery_low_reg    <= BATT_LOW_RST;
            measure_period_reg <= MEASURE_RST;
            mute_length_reg    <= MUTE_RST;
        end
        else if (cfg_xfer)
        begin
            case (cfg.index)
                CFG_WARN_HIGH:      warn_high_reg      <= cfg.data;
                CFG_WARN_LOW:       warn_low_reg       <= cfg.data;
                CFG_CRIT_HIGH:      crit_high_reg      <= cfg.data;
                CFG_CRIT_LOW:       crit_low_reg       <= cfg.data;
                CFG_BATTERY_LOW:    battery_low_reg    <= cfg.data[BATT_W-1:0];
                CFG_MEASURE_PERIOD: measure_period_reg <= cfg.data;
                CFG_MUTE_LENGTH:    mute_length_reg    <= cfg.data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_NORMAL;
            since_measure_reg <= '0;
            since_blink_reg   <= '0;
            since_mute_reg    <= '0;
            blink_phase_reg   <= 1'b0;
            led_reg           <= 1'b0;
            buzzer_reg        <= 1'b0;
        end
        else if (in_xfer)
        begin
            mode_reg          <= mode_next;
            since_measure_reg <= since_measure_next;
            since_blink_reg   <= since_blink_next;
            since_mute_reg    <= since_mute_next;
            blink_phase_reg   <= blink_phase_next;
            led_reg           <= led_next;
            buzzer_reg        <= buzzer_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (out_xfer)
            out_valid_reg <= 1'b0;
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_led_reg    <= led_next;
            out_buzzer_reg <= buzzer_next;
            out_mode_reg   <= mode_next;
            out_eval_reg   <= evaluated_next;
        end
    end

    `TAMU_ASSERT_NEXT(a_xfer_fills_out, clk, rst_n, in_xfer, out_valid_reg)
    `TAMU_ASSERT_IMPLY(a_muted_outputs, clk, rst_n,
        out_valid_reg && out_mode_reg == MODE_MUTED, out_led_reg && !out_buzzer_reg)
    `TAMU_ASSERT_IMPLY(a_quiet_buzzer, clk, rst_n,
        out_valid_reg && (out_mode_reg == MODE_NORMAL || out_mode_reg == MODE_WARNING),
        !out_buzzer_reg)
    `TAMU_ASSERT_NEXT(a_eval_clears, clk, rst_n, in_xfer && evaluated_next,
        since_measure_reg == '0)

endmodule

>>> tb/temperature_alarm_monitor_unit_test.sv
`timescale 1ns / 1ps

module temperature_alarm_monitor_unit_test;
    import tamu_pkg::*;

    localparam int TCNT_W = TIMER_BITS_DEFAULT;
    localparam logic [TCNT_W-1:0] TCNT_MAX = '1;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;
    // index past the last register; a write there must change nothing
    localparam cfg_idx_t CFG_SPARE = 3'd7;
    localparam int QUIET_LIMIT = 2000;
    localparam int NUM_ROWS = 24;

    typedef struct packed {
        logic                     press;
        logic signed [TEMP_W-1:0] temp;
        logic                     fault;
        logic [BATT_W-1:0]        battery;
    } tick_t;

    typedef struct packed {
        logic  led;
        logic  buzzer;
        mode_t mode;
        logic  evaluated;
    } pins_t;

    typedef struct packed {
        logic                  is_reg;
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] data;
        tick_t                 t;
        logic                  typed;
        pins_t                 want;
    } step_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] warn_high;
        logic signed [TEMP_W-1:0] warn_low;
        logic signed [TEMP_W-1:0] crit_high;
        logic signed [TEMP_W-1:0] crit_low;
        logic [CFG_DATA_W-1:0]    batt_raw;
        logic [CFG_DATA_W-1:0]    measure;
        logic [CFG_DATA_W-1:0]    mute;
    } regs_t;

    typedef enum int {
        SEG_CALM,
        SEG_WARN_EDGE,
        SEG_CRIT_EDGE,
        SEG_FAULT,
        SEG_NOISE,
        SEG_EXTREME
    } seg_kind_t;

    logic clk;
    logic rst_n;

    tamu_sample_if sample_ch();
    tamu_result_if result_ch();
    tamu_cfg_if    cfg_ch();

    temperature_alarm_monitor_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    // alarm state as the block should hold it
    logic signed [TEMP_W-1:0] r_warn_high, r_warn_low, r_crit_high, r_crit_low;
    logic [BATT_W-1:0]        r_batt_low;
    logic [PERIOD_W-1:0]      r_measure, r_mute;
    mode_t                    m_mode;
    logic [TCNT_W-1:0]        m_since_measure, m_since_blink, m_since_mute;
    logic                     m_phase, m_led, m_buzzer;

    pins_t pending_pins[$];
    int    mismatches;
    int    quiet_cycles;
    int    send_idle_pct;
    int    recv_stall_pct;

    int        seg_left;
    seg_kind_t seg_kind;
    int        seg_temp;
    int        seg_batt;

    always #5 clk = ~clk;

    function automatic pins_t tick_alarm(tick_t t);
        logic signed [TEMP_W-1:0] temp;
        logic [PERIOD_W-1:0]      blink_len;
        pins_t                    p;
        p.evaluated = 1'b0;
        m_since_measure = (m_since_measure == TCNT_MAX) ? TCNT_MAX : m_since_measure + 1'b1;
        m_since_blink   = (m_since_blink == TCNT_MAX) ? TCNT_MAX : m_since_blink + 1'b1;
        m_since_mute    = (m_since_mute == TCNT_MAX) ? TCNT_MAX : m_since_mute + 1'b1;
        if (t.press && (m_mode == MODE_WARNING || m_mode == MODE_CRITICAL))
        begin
            m_mode = MODE_MUTED;
            m_since_mute = '0;
            m_buzzer = 1'b0;
        end
        if (m_mode == MODE_MUTED && m_since_mute > r_mute)
            m_mode = MODE_NORMAL;
        if (m_since_measure >= r_measure)
        begin
            m_since_measure = '0;
            p.evaluated = 1'b1;
            temp = t.temp;
            if (t.fault)
                temp = '0;
            if (m_mode != MODE_MUTED)
            begin
                if (temp < r_crit_low || temp > r_crit_high || t.battery < r_batt_low)
                    m_mode = MODE_CRITICAL;
                else if (temp < r_warn_low || temp > r_warn_high)
                    m_mode = MODE_WARNING;
                else
                    m_mode = MODE_NORMAL;
            end
        end
        case (m_mode)
            MODE_NORMAL:   blink_len = BLINK_SLOW;
            MODE_WARNING:  blink_len = BLINK_MEDIUM;
            default:       blink_len = BLINK_FAST;
        endcase
        if (m_mode == MODE_MUTED)
        begin
            // solid LED, phase frozen
            m_led = 1'b1;
            m_buzzer = 1'b0;
        end
        else
        begin
            if (m_since_blink >= blink_len)
            begin
                m_since_blink = '0;
                m_phase = ~m_phase;
                m_led = m_phase;
                if (m_mode == MODE_CRITICAL)
                    m_buzzer = m_phase;
            end
            if (m_mode != MODE_CRITICAL)
                m_buzzer = 1'b0;
        end
        p.led = m_led;
        p.buzzer = m_buzzer;
        p.mode = m_mode;
        return p;
    endfunction

    function automatic step_t tick_row(logic press, logic signed [TEMP_W-1:0] temp,
                                       logic fault, logic [BATT_W-1:0] batt);
        step_t s;
        s = '0;
        s.t = '{press, temp, fault, batt};
        return s;
    endfunction

    function automatic step_t tick_row_chk(logic press, logic signed [TEMP_W-1:0] temp,
                                           logic fault, logic [BATT_W-1:0] batt,
                                           logic led, logic buz, mode_t mode, logic eval);
        step_t s;
        s = tick_row(press, temp, fault, batt);
        s.typed = 1'b1;
        s.want = '{led, buz, mode, eval};
        return s;
    endfunction

    function automatic step_t reg_row(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        step_t s;
        s = '0;
        s.is_reg = 1'b1;
        s.idx = idx;
        s.data = data;
        return s;
    endfunction

    // Runs of ticks that hold one kind of reading, so modes settle and timers play out.
    function automatic tick_t pick_tick();
        tick_t t;
        int    lo, hi, swap, thr, v;
        if (seg_left == 0)
        begin
            seg_left = 1 + $urandom_range(39);
            seg_kind = seg_kind_t'($urandom_range(5));
            case (seg_kind)
                SEG_CALM:
                begin
                    lo = r_warn_low;
                    hi = r_warn_high;
                    if (lo > hi)
                    begin
                        swap = lo;
                        lo = hi;
                        hi = swap;
                    end
                    seg_temp = lo + int'($urandom_range(hi - lo));
                end
                SEG_WARN_EDGE:
                begin
                    thr = $urandom_range(1) ? int'(r_warn_high) : int'(r_warn_low);
                    seg_temp = thr + int'($urandom_range(6)) - 3;
                end
                SEG_CRIT_EDGE:
                begin
                    thr = $urandom_range(1) ? int'(r_crit_high) : int'(r_crit_low);
                    seg_temp = thr + int'($urandom_range(6)) - 3;
                end
                SEG_EXTREME:
                    seg_temp = $urandom_range(1) ? int'(TEMP_MAX) : int'(TEMP_MIN);
                default:
                    seg_temp = int'($urandom_range(65535)) - 32768;
            endcase
            case ($urandom_range(3))
                0:       seg_batt = int'(r_batt_low) + int'($urandom_range(4)) - 2;
                1:       seg_batt = $urandom_range(4095);
                default: seg_batt = 4095 - int'($urandom_range(200));
            endcase
            if (seg_batt < 0)
                seg_batt = 0;
            if (seg_batt > 4095)
                seg_batt = 4095;
        end
        seg_left--;
        if (seg_kind == SEG_NOISE)
            v = int'($urandom_range(65535)) - 32768;
        else
            v = seg_temp + int'($urandom_range(2)) - 1;
        t.press = ($urandom_range(29) == 0);
        t.temp = TEMP_W'(v);
        t.fault = (seg_kind == SEG_FAULT) || ($urandom_range(39) == 0);
        t.battery = BATT_W'(seg_batt);
        return t;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic send_tick(tick_t t, logic typed, pins_t want);
        pins_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.button_press   <= t.press;
        sample_ch.temp_sample    <= t.temp;
        sample_ch.sensor_fault   <= t.fault;
        sample_ch.battery_sample <= t.battery;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        p = tick_alarm(t);
        pending_pins.push_back(typed ? want : p);
    endtask

    // valid stays high so back-to-back writes need no gap; caller lowers it
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_WARN_HIGH:      r_warn_high = data;
            CFG_WARN_LOW:       r_warn_low = data;
            CFG_CRIT_HIGH:      r_crit_high = data;
            CFG_CRIT_LOW:       r_crit_low = data;
            CFG_BATTERY_LOW:    r_batt_low = data[BATT_W-1:0];
            CFG_MEASURE_PERIOD: r_measure = data;
            CFG_MUTE_LENGTH:    r_mute = data;
            default:            ;
        endcase
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int send_pct, int stall_pct, regs_t s, int count);
        drain();
        write_reg(CFG_WARN_HIGH, s.warn_high);
        write_reg(CFG_WARN_LOW, s.warn_low);
        write_reg(CFG_CRIT_HIGH, s.crit_high);
        write_reg(CFG_CRIT_LOW, s.crit_low);
        write_reg(CFG_BATTERY_LOW, s.batt_raw);
        write_reg(CFG_MEASURE_PERIOD, s.measure);
        write_reg(CFG_MUTE_LENGTH, s.mute);
        cfg_ch.valid <= 1'b0;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        seg_left = 0;
        repeat (count)
            send_tick(pick_tick(), 1'b0, '0);
    endtask

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin : check_pins
        pins_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_pins.size() == 0)
                report_mismatch("unrequested result", 1, 0);
            else
            begin
                want = pending_pins.pop_front();
                if (result_ch.led_drive !== want.led)
                    report_mismatch("led_drive", result_ch.led_drive, want.led);
                if (result_ch.buzzer_drive !== want.buzzer)
                    report_mismatch("buzzer_drive", result_ch.buzzer_drive, want.buzzer);
                if (result_ch.alarm_mode !== want.mode)
                    report_mismatch("alarm_mode", result_ch.alarm_mode, want.mode);
                if (result_ch.evaluated !== want.evaluated)
                    report_mismatch("evaluated", result_ch.evaluated, want.evaluated);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        step_t rows [NUM_ROWS];
        regs_t mixed;
        clk = 1'b0;
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.button_press = 1'b0;
        sample_ch.temp_sample = '0;
        sample_ch.sensor_fault = 1'b0;
        sample_ch.battery_sample = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_WARN_HIGH;
        cfg_ch.data = '0;
        result_ch.ready = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        seg_left = 0;
        seg_kind = SEG_CALM;
        seg_temp = 0;
        seg_batt = 0;

        r_warn_high = WARN_HIGH_RST;
        r_warn_low = WARN_LOW_RST;
        r_crit_high = CRIT_HIGH_RST;
        r_crit_low = CRIT_LOW_RST;
        r_batt_low = BATT_LOW_RST;
        r_measure = MEASURE_RST;
        r_mute = MUTE_RST;
        m_mode = MODE_NORMAL;
        m_since_measure = '0;
        m_since_blink = '0;
        m_since_mute = '0;
        m_phase = 1'b0;
        m_led = 1'b0;
        m_buzzer = 1'b0;

        rows = '{
            tick_row_chk(1'b0, 16'sd0, 1'b0, 12'd4095, 1'b0, 1'b0, MODE_NORMAL, 1'b0),
            // press while normal does nothing
            tick_row_chk(1'b1, TEMP_MAX, 1'b1, 12'd0, 1'b0, 1'b0, MODE_NORMAL, 1'b0),
            reg_row(CFG_MEASURE_PERIOD, 16'd1),
            tick_row_chk(1'b0, TEMP_MAX, 1'b0, 12'd4095, 1'b0, 1'b0, MODE_CRITICAL, 1'b1),
            tick_row_chk(1'b0, TEMP_MIN, 1'b0, 12'd4095, 1'b0, 1'b0, MODE_CRITICAL, 1'b1),
            tick_row(1'b0, 16'sd4600, 1'b0, 12'd4095),
            tick_row(1'b0, 16'sd5000, 1'b0, 12'd4095),
            tick_row_chk(1'b1, 16'sd5000, 1'b0, 12'd4095, 1'b1, 1'b0, MODE_MUTED, 1'b1),
            tick_row(1'b1, TEMP_MAX, 1'b0, 12'd0),
            reg_row(CFG_MUTE_LENGTH, 16'd0),
            // mute expires, LED left high
            tick_row(1'b0, 16'sd4600, 1'b0, 12'd4095),
            tick_row(1'b0, 16'sd4600, 1'b1, 12'd4095),
            // each default threshold itself, and one count beyond the battery and critical bounds
            tick_row(1'b0, 16'sd4600, 1'b0, 12'd3002),
            tick_row(1'b0, 16'sd4600, 1'b0, 12'd3003),
            tick_row(1'b0, 16'sd3839, 1'b0, 12'd4095),
            tick_row(1'b0, 16'sd3840, 1'b0, 12'd4095),
            tick_row(1'b0, 16'sd4352, 1'b0, 12'd4095),
            tick_row(1'b0, 16'sd5377, 1'b0, 12'd4095),
            tick_row(1'b0, 16'sd5376, 1'b0, 12'd4095),
            tick_row(1'b0, 16'sd4928, 1'b0, 12'd4095),
            reg_row(CFG_MEASURE_PERIOD, 16'd0),
            tick_row(1'b1, 16'sd0, 1'b1, 12'd4095),
            tick_row(1'b1, 16'sd0, 1'b1, 12'd4095),
            tick_row(1'b0, 16'sd4600, 1'b0, 12'd4095)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].is_reg)
            begin
                drain();
                write_reg(rows[i].idx, rows[i].data);
                cfg_ch.valid <= 1'b0;
            end
            else
                send_tick(rows[i].t, rows[i].typed, rows[i].want);
        end

        drain();
        write_reg(CFG_SPARE, 16'hFFFF);

        run_phase(0, 0, '{WARN_HIGH_RST, WARN_LOW_RST, CRIT_HIGH_RST, CRIT_LOW_RST,
                          16'(BATT_LOW_RST), 16'd3, 16'd40}, 190);

        mixed.warn_high = TEMP_W'(int'(WARN_HIGH_RST) + int'($urandom_range(600)) - 300);
        mixed.warn_low  = TEMP_W'(int'(WARN_LOW_RST) + int'($urandom_range(600)) - 300);
        mixed.crit_high = TEMP_W'(int'(CRIT_HIGH_RST) + int'($urandom_range(600)) - 300);
        mixed.crit_low  = TEMP_W'(int'(CRIT_LOW_RST) + int'($urandom_range(600)) - 300);
        mixed.batt_raw  = 16'($urandom_range(4095, 2000));
        mixed.measure   = 16'd1;
        mixed.mute      = 16'd0;
        run_phase(85, 0, mixed, 170);

        // widest window, battery bound at full scale with junk in the upper data bits,
        // mute that can never time out
        run_phase(0, 85, '{TEMP_MAX, TEMP_MIN, TEMP_MAX, TEMP_MIN,
                           16'hFFFF, 16'd1, 16'hFFFF}, 140);

        // low and high bounds swapped, evaluated every tick
        run_phase(12, 12, '{WARN_LOW_RST, WARN_HIGH_RST, CRIT_LOW_RST, CRIT_HIGH_RST,
                            16'd0, 16'd0, 16'd65534}, 120);

        // longest measure period: no evaluation, only timers and blinking
        run_phase(0, 0, '{TEMP_MIN, TEMP_MAX, 16'sd0, 16'sd0,
                          16'd2048, 16'hFFFF, 16'd5}, 60);

        run_phase(12, 12, '{WARN_HIGH_RST, WARN_LOW_RST, CRIT_HIGH_RST, CRIT_LOW_RST,
                            16'(BATT_LOW_RST), 16'd2, 16'd12}, 170);

        drain();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/tamu_pkg.sv
hdl/tamu_sample_if.sv
hdl/tamu_result_if.sv
hdl/tamu_cfg_if.sv
hdl/temperature_alarm_monitor_unit.sv
tb/temperature_alarm_monitor_unit_test.sv
